// ----- rtl/q2e_pkg.sv -----
// Shared constants, types and the arctangent table of the quaternion to Euler unit.
package q2e_pkg;

  // Number formats
  localparam int QUAT_W         = 16;
  localparam int QUAT_FRAC_BITS = 14;
  localparam int ANGLE_FRAC_BITS = 13;
  localparam int PROD_W         = 2 * QUAT_W;
  localparam int ARG_W          = PROD_W + 2;
  localparam int MAG_W          = ARG_W;

  // Pitch argument brought to Q30
  localparam int S_W            = 30;
  localparam int S_SHIFT        = S_W - 2 * QUAT_FRAC_BITS;

  // Square root of 2^60 - s^2
  localparam int SQ_W           = 2 * S_W;
  localparam int REM_W          = SQ_W + 2;
  localparam int ROOT_STEPS     = S_W + 1;
  localparam int ROOT_W         = S_W + 1;

  // CORDIC datapath
  localparam int CORDIC_STEPS   = 30;
  localparam int CW             = 34;
  localparam int NORM_MSB       = 29;
  localparam int POS_W          = $clog2(MAG_W);
  localparam int TURN_W         = 32;

  localparam logic signed [CW-1:0] HALF_TURN    = CW'(64'sd2147483648);
  localparam logic signed [CW-1:0] QUARTER_TURN = CW'(64'sd1073741824);

  // Turns to radians
  localparam logic [TURN_W-1:0] PI_Q30  = 32'd3373259426;
  localparam int                RAD_SH  = 61 - ANGLE_FRAC_BITS;
  localparam int                RAD_W   = 2 * TURN_W + 1 - RAD_SH + 1;

  // Output fields
  localparam int ROLL_W  = 16;
  localparam int PITCH_W = 15;
  localparam int YAW_W   = 16;

  typedef struct packed {
    logic neg_x;
    logic neg_y;
    logic zero;
    logic clamp;
  } lane_flags_t;

  typedef struct packed {
    logic [MAG_W-1:0] ax;
    logic [MAG_W-1:0] ay;
    lane_flags_t      flags;
  } vec_t;

  typedef struct packed {
    vec_t        roll;
    vec_t        yaw;
    lane_flags_t pitch_flags;
  } side_t;

  typedef struct packed {
    side_t          side;
    logic [S_W-1:0] s;
  } front_t;

  // Arctangent of 2^-i in binary turns (2^32 is one turn)
  function automatic logic [TURN_W-1:0] atan_turn(input logic [4:0] i);
    logic [TURN_W-1:0] r;
    case (i)
      5'd0:    r = 32'h20000000;
      5'd1:    r = 32'h12E4051E;
      5'd2:    r = 32'h09FB385B;
      5'd3:    r = 32'h051111D4;
      5'd4:    r = 32'h028B0D43;
      5'd5:    r = 32'h0145D7E1;
      5'd6:    r = 32'h00A2F61E;
      5'd7:    r = 32'h00517C55;
      5'd8:    r = 32'h0028BE53;
      5'd9:    r = 32'h00145F2F;
      5'd10:   r = 32'h000A2F98;
      5'd11:   r = 32'h000517CC;
      5'd12:   r = 32'h00028BE6;
      5'd13:   r = 32'h000145F3;
      5'd14:   r = 32'h0000A2F9;
      5'd15:   r = 32'h0000517C;
      5'd16:   r = 32'h000028BE;
      5'd17:   r = 32'h0000145F;
      5'd18:   r = 32'h00000A2F;
      5'd19:   r = 32'h00000517;
      5'd20:   r = 32'h0000028B;
      5'd21:   r = 32'h00000145;
      5'd22:   r = 32'h000000A2;
      5'd23:   r = 32'h00000051;
      5'd24:   r = 32'h00000028;
      5'd25:   r = 32'h00000014;
      5'd26:   r = 32'h0000000A;
      5'd27:   r = 32'h00000005;
      5'd28:   r = 32'h00000002;
      5'd29:   r = 32'h00000001;
      default: r = '0;
    endcase
    return r;
  endfunction

  // Magnitude of a signed argument
  function automatic logic [MAG_W-1:0] mag_of(input logic signed [ARG_W-1:0] v);
    logic [MAG_W-1:0] r;
    r = v[ARG_W-1] ? MAG_W'(-v) : MAG_W'(v);
    return r;
  endfunction

endpackage

// ----- rtl/q2e_front.sv -----
// Product, sum and magnitude stages that form the three angle arguments.
module q2e_front import q2e_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  input  logic signed [QUAT_W-1:0] quat_x_i,
  input  logic signed [QUAT_W-1:0] quat_y_i,
  input  logic signed [QUAT_W-1:0] quat_z_i,
  input  logic signed [QUAT_W-1:0] quat_w_i,
  output logic                     valid_o,
  output front_t                   front_o
);

  localparam logic signed [ARG_W-1:0] ONE = ARG_W'(1) << (2 * QUAT_FRAC_BITS);
  localparam logic [MAG_W-1:0] ONE_MAG = MAG_W'(1) << (2 * QUAT_FRAC_BITS);

  logic [2:0] v_q;

  logic signed [PROD_W-1:0] wx_q, yz_q, xx_q, yy_q, wz_q, xy_q, zz_q, wy_q, zx_q;
  logic signed [ARG_W-1:0]  sinr_q, cosr_q, siny_q, cosy_q, sinp_q;
  logic signed [ARG_W-1:0]  sinr_d, cosr_d, siny_d, cosy_d, sinp_d;
  front_t                   front_q, front_d;
  logic [MAG_W-1:0]         pm;

  function automatic logic signed [ARG_W-1:0] ext(input logic signed [PROD_W-1:0] p);
    return {{(ARG_W - PROD_W){p[PROD_W-1]}}, p};
  endfunction

  // Advance the valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[1:0], valid_i};
    end
  end

  // Form the pair products
  always_ff @(posedge clk_i) begin
    wx_q <= quat_w_i * quat_x_i;
    yz_q <= quat_y_i * quat_z_i;
    xx_q <= quat_x_i * quat_x_i;
    yy_q <= quat_y_i * quat_y_i;
    wz_q <= quat_w_i * quat_z_i;
    xy_q <= quat_x_i * quat_y_i;
    zz_q <= quat_z_i * quat_z_i;
    wy_q <= quat_w_i * quat_y_i;
    zx_q <= quat_z_i * quat_x_i;
  end

  // Sum the products into sine and cosine terms
  always_comb begin
    sinr_d = (ext(wx_q) + ext(yz_q)) <<< 1;
    cosr_d = ONE - ((ext(xx_q) + ext(yy_q)) <<< 1);
    siny_d = (ext(wz_q) + ext(xy_q)) <<< 1;
    cosy_d = ONE - ((ext(yy_q) + ext(zz_q)) <<< 1);
    sinp_d = (ext(wy_q) - ext(zx_q)) <<< 1;
  end

  always_ff @(posedge clk_i) begin
    sinr_q <= sinr_d;
    cosr_q <= cosr_d;
    siny_q <= siny_d;
    cosy_q <= cosy_d;
    sinp_q <= sinp_d;
  end

  // Take magnitudes, quadrant flags and the pitch saturation test
  always_comb begin
    pm = mag_of(sinp_q);
    front_d.side.roll.ax          = mag_of(cosr_q);
    front_d.side.roll.ay          = mag_of(sinr_q);
    front_d.side.roll.flags.neg_x = cosr_q[ARG_W-1];
    front_d.side.roll.flags.neg_y = sinr_q[ARG_W-1];
    front_d.side.roll.flags.zero  = (cosr_q == '0) && (sinr_q == '0);
    front_d.side.roll.flags.clamp = 1'b0;
    front_d.side.yaw.ax           = mag_of(cosy_q);
    front_d.side.yaw.ay           = mag_of(siny_q);
    front_d.side.yaw.flags.neg_x  = cosy_q[ARG_W-1];
    front_d.side.yaw.flags.neg_y  = siny_q[ARG_W-1];
    front_d.side.yaw.flags.zero   = (cosy_q == '0) && (siny_q == '0);
    front_d.side.yaw.flags.clamp  = 1'b0;
    front_d.s                     = S_W'(pm << S_SHIFT);
    front_d.side.pitch_flags.neg_x = 1'b0;
    front_d.side.pitch_flags.neg_y = sinp_q[ARG_W-1];
    front_d.side.pitch_flags.zero  = (front_d.s == '0);
    front_d.side.pitch_flags.clamp = (pm >= ONE_MAG);
  end

  always_ff @(posedge clk_i) begin
    front_q <= front_d;
  end

  assign valid_o = v_q[2];
  assign front_o = front_q;

endmodule

// ----- rtl/q2e_sqrt.sv -----
// Pipelined square root of 2^60 - s^2, one root bit per stage.
module q2e_sqrt import q2e_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  front_t            front_i,
  output logic              valid_o,
  output side_t             side_o,
  output logic [S_W-1:0]    s_o,
  output logic [ROOT_W-1:0] root_o
);

  localparam logic [SQ_W:0] FULL = (SQ_W + 1)'(1) << SQ_W;

  logic              vm_q;
  logic [SQ_W-1:0]   sq_q;
  front_t            fm_q;

  logic              v_q    [ROOT_STEPS+1];
  logic [REM_W-1:0]  rem_q  [ROOT_STEPS+1];
  logic [REM_W-1:0]  root_q [ROOT_STEPS+1];
  front_t            f_q    [ROOT_STEPS+1];

  // Hold the valid bits of the square and subtract stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vm_q    <= 1'b0;
      v_q[0]  <= 1'b0;
    end else begin
      vm_q    <= valid_i;
      v_q[0]  <= vm_q;
    end
  end

  // Square s at full width, then subtract from one
  always_ff @(posedge clk_i) begin
    sq_q      <= front_i.s * front_i.s;
    fm_q      <= front_i;
    rem_q[0]  <= REM_W'(FULL - {1'b0, sq_q});
    root_q[0] <= '0;
    f_q[0]    <= fm_q;
  end

  // Resolve one root bit per stage
  for (genvar j = 0; j < ROOT_STEPS; j++) begin : g_step
    localparam int K = ROOT_STEPS - 1 - j;
    localparam logic [REM_W-1:0] BITV = REM_W'(1) << (2 * K);

    logic [REM_W-1:0] trial;
    logic             ge;
    logic [REM_W-1:0] rem_d;
    logic [REM_W-1:0] root_d;

    always_comb begin
      trial  = root_q[j] + BITV;
      ge     = rem_q[j] >= trial;
      rem_d  = ge ? rem_q[j] - trial : rem_q[j];
      root_d = ge ? (root_q[j] >> 1) + BITV : root_q[j] >> 1;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[j+1] <= 1'b0;
      end else begin
        v_q[j+1] <= v_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[j+1]  <= rem_d;
      root_q[j+1] <= root_d;
      f_q[j+1]    <= f_q[j];
    end
  end

  assign valid_o = v_q[ROOT_STEPS];
  assign side_o  = f_q[ROOT_STEPS].side;
  assign s_o     = f_q[ROOT_STEPS].s;
  assign root_o  = root_q[ROOT_STEPS][ROOT_W-1:0];

endmodule

// ----- rtl/q2e_cordic.sv -----
// Vectoring CORDIC lane: normalise, iterate, then place the angle in its quadrant.
module q2e_cordic import q2e_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  vec_t                 vec_i,
  output logic                 valid_o,
  output logic signed [CW-1:0] turns_o,
  output lane_flags_t          flags_o
);

  // Normalise stage one: find the leading one
  logic              n1_v_q;
  vec_t              n1_q;
  logic [POS_W-1:0]  pos_q, pos_d;
  logic [MAG_W-1:0]  or_v;

  always_comb begin
    or_v  = vec_i.ax | vec_i.ay;
    pos_d = '0;
    for (int b = 0; b < MAG_W; b++) begin
      if (or_v[b]) begin
        pos_d = POS_W'(b);
      end
    end
  end

  // Normalise stage two: shift the leading one to its place
  logic signed [CW-1:0] x0_d, y0_d;
  logic [POS_W-1:0]     shr, shl;

  always_comb begin
    shr = pos_q - POS_W'(NORM_MSB);
    shl = POS_W'(NORM_MSB) - pos_q;
    if (pos_q >= POS_W'(NORM_MSB)) begin
      x0_d = CW'(n1_q.ax >> shr);
      y0_d = CW'(n1_q.ay >> shr);
    end else begin
      x0_d = CW'(n1_q.ax << shl);
      y0_d = CW'(n1_q.ay << shl);
    end
  end

  logic                 v_q [CORDIC_STEPS+1];
  logic signed [CW-1:0] x_q [CORDIC_STEPS+1];
  logic signed [CW-1:0] y_q [CORDIC_STEPS+1];
  logic signed [CW-1:0] z_q [CORDIC_STEPS+1];
  lane_flags_t          f_q [CORDIC_STEPS+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n1_v_q <= 1'b0;
      v_q[0] <= 1'b0;
    end else begin
      n1_v_q <= valid_i;
      v_q[0] <= n1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    n1_q   <= vec_i;
    pos_q  <= pos_d;
    x_q[0] <= x0_d;
    y_q[0] <= y0_d;
    z_q[0] <= '0;
    f_q[0] <= n1_q.flags;
  end

  // Rotate towards the x axis, one micro-rotation per stage
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_iter
    localparam logic signed [CW-1:0] ATAN = CW'(atan_turn(5'(i)));

    logic signed [CW-1:0] dx, dy;
    logic                 up;

    always_comb begin
      dx = y_q[i] >>> i;
      dy = x_q[i] >>> i;
      up = y_q[i] > 0;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i+1] <= 1'b0;
      end else begin
        v_q[i+1] <= v_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      x_q[i+1] <= up ? x_q[i] + dx : x_q[i] - dx;
      y_q[i+1] <= up ? y_q[i] - dy : y_q[i] + dy;
      z_q[i+1] <= up ? z_q[i] + ATAN : z_q[i] - ATAN;
      f_q[i+1] <= f_q[i];
    end
  end

  // Place the angle in its quadrant
  logic                 vo_q;
  logic signed [CW-1:0] t_q, t_d;
  lane_flags_t          fo_q;

  always_comb begin
    t_d = z_q[CORDIC_STEPS];
    if (f_q[CORDIC_STEPS].neg_x) begin
      t_d = HALF_TURN - t_d;
    end
    if (f_q[CORDIC_STEPS].neg_y) begin
      t_d = -t_d;
    end
    if (f_q[CORDIC_STEPS].zero) begin
      t_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else begin
      vo_q <= v_q[CORDIC_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    t_q  <= t_d;
    fo_q <= f_q[CORDIC_STEPS];
  end

  assign valid_o = vo_q;
  assign turns_o = t_q;
  assign flags_o = fo_q;

endmodule

// ----- rtl/q2e_rad.sv -----
// Turns to radians: scale by pi, round half up, restore the sign.
module q2e_rad import q2e_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  input  logic signed [CW-1:0]    turns_i,
  input  lane_flags_t             flags_i,
  output logic                    valid_o,
  output logic signed [RAD_W-1:0] rad_o,
  output logic                    clamp_o
);

  localparam int PW = 2 * TURN_W;
  localparam logic [PW:0] HALF_LSB = (PW + 1)'(1) << (RAD_SH - 1);

  logic                 v1_q, v2_q;
  logic signed [CW-1:0] t_eff;
  logic [TURN_W-1:0]    m;
  logic [PW-1:0]        prod_q;
  logic                 neg_q, clamp1_q, clamp2_q;
  logic [PW:0]          sum;
  logic [RAD_W-1:0]     r;
  logic signed [RAD_W-1:0] rad_q;

  // Replace a saturated pitch by the quarter turn, then take the magnitude
  always_comb begin
    if (flags_i.clamp) begin
      t_eff = flags_i.neg_y ? -QUARTER_TURN : QUARTER_TURN;
    end else begin
      t_eff = turns_i;
    end
    m = t_eff[CW-1] ? TURN_W'(-t_eff) : TURN_W'(t_eff);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  // Round the scaled magnitude and apply the sign
  always_comb begin
    sum = {1'b0, prod_q} + HALF_LSB;
    r   = RAD_W'(sum >> RAD_SH);
  end

  always_ff @(posedge clk_i) begin
    prod_q   <= m * PI_Q30;
    neg_q    <= t_eff[CW-1];
    clamp1_q <= flags_i.clamp;
    rad_q    <= neg_q ? -$signed(r) : $signed(r);
    clamp2_q <= clamp1_q;
  end

  assign valid_o = v2_q;
  assign rad_o   = rad_q;
  assign clamp_o = clamp2_q;

endmodule

// ----- rtl/quaternion_to_euler_unit.sv -----
// Top level of the quaternion to Euler angle unit.
//
//  channel  | handshake           | payload
//  ---------+---------------------+-------------------------------------------
//  command  | start / busy        | quat_x_i, quat_y_i, quat_z_i, quat_w_i
//  result   | done_o (one cycle)  | roll_o, pitch_o, yaw_o, pitch_clamped_o
//
// One quaternion is taken in every cycle; busy stays low.
// Each result comes out on done_o after its transaction has passed 3 front
// stages, 33 square root stages, 33 CORDIC stages, 2 scaling stages and the
// output register, all in series.
// Reset clears only the valid bits of the pipeline; no transaction survives it.
// The receiver cannot stall, so nothing in the pipeline ever holds.
module quaternion_to_euler_unit import q2e_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic signed [QUAT_W-1:0]   quat_x_i,
  input  logic signed [QUAT_W-1:0]   quat_y_i,
  input  logic signed [QUAT_W-1:0]   quat_z_i,
  input  logic signed [QUAT_W-1:0]   quat_w_i,
  output logic                       done_o,
  output logic signed [ROLL_W-1:0]   roll_o,
  output logic signed [PITCH_W-1:0]  pitch_o,
  output logic signed [YAW_W-1:0]    yaw_o,
  output logic                       pitch_clamped_o
);

  logic    f_v;
  front_t  f_data;
  logic    q_v;
  side_t   q_side;
  logic [S_W-1:0]    q_s;
  logic [ROOT_W-1:0] q_root;
  vec_t    pitch_vec;

  logic                 cr_v, cp_v, cy_v;
  logic signed [CW-1:0] cr_t, cp_t, cy_t;
  lane_flags_t          cr_f, cp_f, cy_f;

  logic                    rr_v, rp_v, ry_v;
  logic signed [RAD_W-1:0] rr_a, rp_a, ry_a;
  logic                    rr_c, rp_c, ry_c;

  logic                     done_q;
  logic signed [ROLL_W-1:0]  roll_q;
  logic signed [PITCH_W-1:0] pitch_q;
  logic signed [YAW_W-1:0]   yaw_q;
  logic                     clamp_q;

  assign busy = 1'b0;

  q2e_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (start && !busy),
    .quat_x_i (quat_x_i),
    .quat_y_i (quat_y_i),
    .quat_z_i (quat_z_i),
    .quat_w_i (quat_w_i),
    .valid_o  (f_v),
    .front_o  (f_data)
  );

  q2e_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (f_v),
    .front_i (f_data),
    .valid_o (q_v),
    .side_o  (q_side),
    .s_o     (q_s),
    .root_o  (q_root)
  );

  // Build the pitch vector (cosine from the root, sine from s)
  always_comb begin
    pitch_vec.ax    = MAG_W'(q_root);
    pitch_vec.ay    = MAG_W'(q_s);
    pitch_vec.flags = q_side.pitch_flags;
  end

  q2e_cordic u_cordic_roll (
    .clk_i (clk_i), .rst_ni (rst_ni), .valid_i (q_v), .vec_i (q_side.roll),
    .valid_o (cr_v), .turns_o (cr_t), .flags_o (cr_f)
  );

  q2e_cordic u_cordic_pitch (
    .clk_i (clk_i), .rst_ni (rst_ni), .valid_i (q_v), .vec_i (pitch_vec),
    .valid_o (cp_v), .turns_o (cp_t), .flags_o (cp_f)
  );

  q2e_cordic u_cordic_yaw (
    .clk_i (clk_i), .rst_ni (rst_ni), .valid_i (q_v), .vec_i (q_side.yaw),
    .valid_o (cy_v), .turns_o (cy_t), .flags_o (cy_f)
  );

  q2e_rad u_rad_roll (
    .clk_i (clk_i), .rst_ni (rst_ni), .valid_i (cr_v), .turns_i (cr_t),
    .flags_i (cr_f), .valid_o (rr_v), .rad_o (rr_a), .clamp_o (rr_c)
  );

  q2e_rad u_rad_pitch (
    .clk_i (clk_i), .rst_ni (rst_ni), .valid_i (cp_v), .turns_i (cp_t),
    .flags_i (cp_f), .valid_o (rp_v), .rad_o (rp_a), .clamp_o (rp_c)
  );

  q2e_rad u_rad_yaw (
    .clk_i (clk_i), .rst_ni (rst_ni), .valid_i (cy_v), .turns_i (cy_t),
    .flags_i (cy_f), .valid_o (ry_v), .rad_o (ry_a), .clamp_o (ry_c)
  );

  // Saturate an angle to a narrower signed field
  function automatic logic signed [ROLL_W-1:0] sat16(input logic signed [RAD_W-1:0] v);
    logic signed [RAD_W-1:0] hi, lo;
    hi = RAD_W'((1 <<< (ROLL_W - 1)) - 1);
    lo = -RAD_W'(1 <<< (ROLL_W - 1));
    if (v > hi) begin
      return ROLL_W'(hi);
    end else if (v < lo) begin
      return ROLL_W'(lo);
    end
    return ROLL_W'(v);
  endfunction

  function automatic logic signed [PITCH_W-1:0] sat15(input logic signed [RAD_W-1:0] v);
    logic signed [RAD_W-1:0] hi, lo;
    hi = RAD_W'((1 <<< (PITCH_W - 1)) - 1);
    lo = -RAD_W'(1 <<< (PITCH_W - 1));
    if (v > hi) begin
      return PITCH_W'(hi);
    end else if (v < lo) begin
      return PITCH_W'(lo);
    end
    return PITCH_W'(v);
  endfunction

  // Register the result transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= rr_v && rp_v && ry_v;
    end
  end

  always_ff @(posedge clk_i) begin
    roll_q  <= sat16(rr_a);
    pitch_q <= sat15(rp_a);
    yaw_q   <= sat16(ry_a);
    clamp_q <= rp_c && !rr_c && !ry_c;
  end

  assign done_o          = done_q;
  assign roll_o          = roll_q;
  assign pitch_o         = pitch_q;
  assign yaw_o           = yaw_q;
  assign pitch_clamped_o = clamp_q;

endmodule

// ----- sim/quaternion_to_euler_unit_tb.sv -----
// Self-checking testbench of the quaternion to Euler angle unit.
`timescale 1ns / 1ps

module quaternion_to_euler_unit_tb;
  import q2e_pkg::*;

  localparam int  N_RANDOM     = 1350;
  localparam int  LATENCY      = 72;
  localparam int  N_REPORT     = 10;
  localparam longint UNIT_PROD = longint'(1) << (2 * QUAT_FRAC_BITS);

  typedef struct packed {
    logic signed [ROLL_W-1:0]  roll;
    logic signed [PITCH_W-1:0] pitch;
    logic signed [YAW_W-1:0]   yaw;
    logic                      clamped;
  } euler_t;

  typedef struct {
    logic signed [QUAT_W-1:0] x, y, z, w;
    logic                     known;
    euler_t                   angles;
  } quat_row_t;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      start = 1'b0;
  logic                      busy;
  logic signed [QUAT_W-1:0]  quat_x_i = '0;
  logic signed [QUAT_W-1:0]  quat_y_i = '0;
  logic signed [QUAT_W-1:0]  quat_z_i = '0;
  logic signed [QUAT_W-1:0]  quat_w_i = '0;
  logic                      done_o;
  logic signed [ROLL_W-1:0]  roll_o;
  logic signed [PITCH_W-1:0] pitch_o;
  logic signed [YAW_W-1:0]   yaw_o;
  logic                      pitch_clamped_o;

  euler_t    pending_angles[$];
  euler_t    known_angles[$];
  logic      has_known[$];
  int        n_sent = 0;
  int        n_checked = 0;
  int        n_mismatch = 0;
  int        n_clamped = 0;
  int        n_flipped = 0;
  logic      cur_known = 1'b0;
  euler_t    cur_angles;

  quaternion_to_euler_unit u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .quat_x_i        (quat_x_i),
    .quat_y_i        (quat_y_i),
    .quat_z_i        (quat_z_i),
    .quat_w_i        (quat_w_i),
    .done_o          (done_o),
    .roll_o          (roll_o),
    .pitch_o         (pitch_o),
    .yaw_o           (yaw_o),
    .pitch_clamped_o (pitch_clamped_o)
  );

  // Clock: 10 ns period
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // First-quadrant CORDIC angle in turns of (ax, ay), not both zero
  function automatic longint cordic_turns(input longint unsigned ax, input longint unsigned ay);
    longint vx, vy, acc, dx, dy;
    acc = 0;
    while ((ax | ay) >= (64'd1 << 30)) begin
      ax = ax >> 1;
      ay = ay >> 1;
    end
    while ((ax | ay) < (64'd1 << 29)) begin
      ax = ax << 1;
      ay = ay << 1;
    end
    vx = longint'(ax);
    vy = longint'(ay);
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = vy >>> i;
      dy = vx >>> i;
      if (vy > 0) begin
        vx += dx; vy -= dy; acc += longint'(atan_turn(5'(i)));
      end else begin
        vx -= dx; vy += dy; acc -= longint'(atan_turn(5'(i)));
      end
    end
    return acc;
  endfunction

  function automatic longint unsigned abs64(input longint v);
    return v < 0 ? longint'(0) - v : v;
  endfunction

  function automatic longint atan2_turns(input longint sy, input longint sx);
    longint a;
    if (sx == 0 && sy == 0) return 0;
    a = cordic_turns(abs64(sx), abs64(sy));
    if (sx < 0) a = 64'sd2147483648 - a;
    if (sy < 0) a = -a;
    return a;
  endfunction

  // Round half up, sign applied after
  function automatic longint turns_to_radians(input longint t);
    longint unsigned r;
    r = (abs64(t) * 64'd3373259426 + (64'd1 << (RAD_SH - 1))) >> RAD_SH;
    return t < 0 ? -longint'(r) : longint'(r);
  endfunction

  function automatic longint unsigned root_floor(input longint unsigned n);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n -= res + b;
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic longint clip(input longint v, input int w);
    longint hi, lo;
    hi = (longint'(1) << (w - 1)) - 1;
    lo = -(longint'(1) << (w - 1));
    return v > hi ? hi : (v < lo ? lo : v);
  endfunction

  // Expected angles of one quaternion
  function automatic euler_t euler_of_quat(input logic signed [QUAT_W-1:0] qx, qy, qz, qw);
    longint x, y, z, w, sinr, cosr, siny, cosy, sinp, p, t;
    longint unsigned mag, s, c;
    euler_t e;
    x = qx; y = qy; z = qz; w = qw;
    sinr = 2 * (w * x + y * z);
    cosr = UNIT_PROD - 2 * (x * x + y * y);
    siny = 2 * (w * z + x * y);
    cosy = UNIT_PROD - 2 * (y * y + z * z);
    sinp = 2 * (w * y - z * x);
    mag  = abs64(sinp);
    e.clamped = 1'b0;
    if (mag >= UNIT_PROD) begin
      p = turns_to_radians(64'sd1073741824);
      if (sinp < 0) p = -p;
      e.clamped = 1'b1;
    end else begin
      s = mag << S_SHIFT;
      c = root_floor((64'd1 << 60) - s * s);
      t = (s == 0) ? 0 : cordic_turns(c, s);
      if (sinp < 0) t = -t;
      p = turns_to_radians(t);
    end
    e.roll  = ROLL_W'(clip(turns_to_radians(atan2_turns(sinr, cosr)), ROLL_W));
    e.pitch = PITCH_W'(clip(p, PITCH_W));
    e.yaw   = YAW_W'(clip(turns_to_radians(atan2_turns(siny, cosy)), YAW_W));
    return e;
  endfunction

  // Record each accepted transaction and check each result
  always @(posedge clk_i) begin
    euler_t exp_a;
    if (rst_ni && start && !busy) begin
      exp_a = euler_of_quat(quat_x_i, quat_y_i, quat_z_i, quat_w_i);
      pending_angles.push_back(exp_a);
      has_known.push_back(cur_known);
      known_angles.push_back(cur_angles);
      if (exp_a.clamped) n_clamped++;
      if (exp_a.roll > 12868 || exp_a.roll < -12868) n_flipped++;
    end
    if (rst_ni && done_o) begin
      if (pending_angles.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= N_REPORT)
          $display("ERROR: result with none expected: roll %0d pitch %0d yaw %0d",
                   roll_o, pitch_o, yaw_o);
      end else begin
        exp_a = pending_angles.pop_front();
        if (has_known.pop_front()) begin
          // Typed-in value must agree with the predictor too
          if (known_angles[0] != exp_a) begin
            n_mismatch++;
            if (n_mismatch <= N_REPORT)
              $display("ERROR: table row disagrees with predictor at result %0d", n_checked);
          end
        end
        void'(known_angles.pop_front());
        if (roll_o !== exp_a.roll || pitch_o !== exp_a.pitch || yaw_o !== exp_a.yaw ||
            pitch_clamped_o !== exp_a.clamped) begin
          n_mismatch++;
          if (n_mismatch <= N_REPORT)
            $display({"ERROR: result %0d exp roll %0d pitch %0d yaw %0d clamp %0b,",
                      " got %0d %0d %0d %0b"},
                     n_checked, exp_a.roll, exp_a.pitch, exp_a.yaw, exp_a.clamped,
                     roll_o, pitch_o, yaw_o, pitch_clamped_o);
        end
        n_checked++;
      end
    end
  end

  // Idle gap: mostly none, some short, a few long
  task automatic idle_gap(input bit quiet);
    int n;
    int r;
    r = $urandom_range(0, 19);
    n = quiet ? 0 : (r < 12 ? 0 : (r < 18 ? $urandom_range(1, 3) : $urandom_range(10, 40)));
    if (n > 0) begin
      start = 1'b0;
      repeat (n) @(negedge clk_i);
    end
  endtask

  // Present one transaction and hold it until accepted
  task automatic send_quat(input logic signed [QUAT_W-1:0] qx, qy, qz, qw, input bit quiet);
    idle_gap(quiet);
    start    = 1'b1;
    quat_x_i = qx;
    quat_y_i = qy;
    quat_z_i = qz;
    quat_w_i = qw;
    forever begin
      @(posedge clk_i);
      if (!busy) break;
    end
    n_sent++;
    @(negedge clk_i);
  endtask

  // Random quaternion: mostly unit length, some near gimbal lock, some raw bits
  task automatic random_quat(output logic signed [QUAT_W-1:0] qx, qy, qz, qw);
    real a, b, c, d, norm;
    int sel;
    sel = $urandom_range(0, 19);
    if (sel < 4) begin
      {qx, qy, qz, qw} = {$urandom, $urandom};
    end else if (sel < 7) begin
      qy = QUAT_W'($urandom_range(0, 23170)) - QUAT_W'(11585);
      qw = $urandom_range(0, 1) ? qy : -qy;
      qx = QUAT_W'($urandom_range(0, 8)) - QUAT_W'(4);
      qz = QUAT_W'($urandom_range(0, 8)) - QUAT_W'(4);
    end else begin
      do begin
        a = real'(int'($urandom_range(0, 65535)) - 32768);
        b = real'(int'($urandom_range(0, 65535)) - 32768);
        c = real'(int'($urandom_range(0, 65535)) - 32768);
        d = real'(int'($urandom_range(0, 65535)) - 32768);
        norm = $sqrt(a * a + b * b + c * c + d * d);
      end while (norm < 1.0);
      qx = QUAT_W'($rtoi(a / norm * 16384.0));
      qy = QUAT_W'($rtoi(b / norm * 16384.0));
      qz = QUAT_W'($rtoi(c / norm * 16384.0));
      qw = QUAT_W'($rtoi(d / norm * 16384.0));
    end
  endtask

  function automatic quat_row_t mk_row(input int x, y, z, w, input logic k,
                                       input int r, p, yw, input logic cl);
    quat_row_t q;
    q.x = QUAT_W'(x); q.y = QUAT_W'(y); q.z = QUAT_W'(z); q.w = QUAT_W'(w);
    q.known = k;
    q.angles.roll = ROLL_W'(r); q.angles.pitch = PITCH_W'(p);
    q.angles.yaw = YAW_W'(yw); q.angles.clamped = cl;
    return q;
  endfunction

  // Directed table, then random stimulus
  initial begin
    quat_row_t rows[$];
    logic signed [QUAT_W-1:0] rx, ry, rz, rw;
    int seg_left;
    bit quiet;
    rows.push_back(mk_row(0, 0, 0, 16384, 1, 0, 0, 0, 0));          // identity
    rows.push_back(mk_row(0, 0, 0, 0, 1, 0, 0, 0, 0));              // zero vector
    rows.push_back(mk_row(0, 16384, 0, 16384, 1, 25736, 12868, 25736, 1));    // clamp up
    rows.push_back(mk_row(0, -16384, 0, 16384, 1, 25736, -12868, 25736, 1));  // clamp down
    rows.push_back(mk_row(16384, 0, 0, 0, 1, 25736, 0, 0, 0));      // half turn about x
    rows.push_back(mk_row(0, 0, 16384, 0, 1, 0, 0, 25736, 0));      // half turn about z
    rows.push_back(mk_row(0, 11585, 0, 11585, 0, 0, 0, 0, 0));      // just below lock
    rows.push_back(mk_row(0, 11586, 0, 11586, 0, 0, 0, 0, 0));      // just at lock
    rows.push_back(mk_row(11585, 0, 0, 11585, 0, 0, 0, 0, 0));
    rows.push_back(mk_row(0, 0, -11585, 11585, 0, 0, 0, 0, 0));
    rows.push_back(mk_row(-16384, -16384, -16384, -16384, 0, 0, 0, 0, 0));
    rows.push_back(mk_row(32767, 32767, 32767, 32767, 0, 0, 0, 0, 0));
    rows.push_back(mk_row(-32768, -32768, -32768, -32768, 0, 0, 0, 0, 0));
    rows.push_back(mk_row(-32768, 32767, -32768, 32767, 0, 0, 0, 0, 0));
    rows.push_back(mk_row(1, -1, 1, -1, 0, 0, 0, 0, 0));
    rows.push_back(mk_row(8192, 8192, 8192, 8192, 0, 0, 0, 0, 0));
    rows.push_back(mk_row(-8192, 8192, 8192, -8192, 0, 0, 0, 0, 0));

    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (rows[i]) begin
      cur_known  = rows[i].known;
      cur_angles = rows[i].angles;
      send_quat(rows[i].x, rows[i].y, rows[i].z, rows[i].w, 1'b0);
    end
    cur_known = 1'b0;

    seg_left = 0;
    quiet = 1'b0;
    for (int i = 0; i < N_RANDOM; i++) begin
      // Alternate stretches with and without idle cycles
      if (seg_left == 0) begin
        seg_left = $urandom_range(20, 120);
        quiet = $urandom_range(0, 2) == 0;
      end
      seg_left--;
      if (i == N_RANDOM / 2) begin
        // Hold off until the pipeline has drained
        start = 1'b0;
        while (pending_angles.size() != 0) @(negedge clk_i);
      end
      random_quat(rx, ry, rz, rw);
      send_quat(rx, ry, rz, rw, quiet);
    end
    start = 1'b0;

    while (pending_angles.size() != 0) @(negedge clk_i);
    repeat (LATENCY + 8) @(negedge clk_i);

    $display("Sent %0d quaternions, checked %0d results, %0d mismatches.",
             n_sent, n_checked, n_mismatch);
    $display("Covered %0d saturated pitches and %0d rolls beyond a quarter turn.",
             n_clamped, n_flipped);
    if (n_mismatch == 0 && n_checked == n_sent) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #3ms;
    $display("Timeout with %0d results outstanding.", pending_angles.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/q2e_pkg.sv
rtl/q2e_front.sv
rtl/q2e_sqrt.sv
rtl/q2e_cordic.sv
rtl/q2e_rad.sv
rtl/quaternion_to_euler_unit.sv
sim/quaternion_to_euler_unit_tb.sv
